FILE: src/cgb_pkg.sv
package cgb_pkg;

  localparam int GLYPH_WIDTH  = 5;
  localparam int GLYPH_HEIGHT = 7;
  localparam int FONT_FIRST   = 32;
  localparam int FONT_COUNT   = 95;
  localparam int FONT_QMARK   = 63;

  // Signed working width for box corners and sizes
  localparam int CW = 14;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t w;
    coord_t h;
  } box_t;

  typedef struct packed {
    logic busy;
    logic wr_en;
  } walk_stat_t;

  typedef enum logic [2:0] {
    FN_FILL   = 3'd0,
    FN_STROKE = 3'd1,
    FN_CUT    = 3'd2,
    FN_CHAR   = 3'd3,
    FN_READ   = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BOX,
    ST_DRAIN,
    ST_READ,
    ST_RESP
  } state_t;

  typedef logic [GLYPH_WIDTH-1:0] glyph_row_t;

  localparam glyph_row_t FONT [FONT_COUNT][GLYPH_HEIGHT] = '{
    '{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0},
    '{5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd0, 5'd4},
    '{5'd10, 5'd10, 5'd20, 5'd0, 5'd0, 5'd0, 5'd0},
    '{5'd10, 5'd10, 5'd31, 5'd10, 5'd31, 5'd10, 5'd10},
    '{5'd4, 5'd15, 5'd20, 5'd14, 5'd5, 5'd30, 5'd4},
    '{5'd25, 5'd25, 5'd2, 5'd4, 5'd8, 5'd19, 5'd19},
    '{5'd12, 5'd18, 5'd20, 5'd8, 5'd21, 5'd18, 5'd13},
    '{5'd4, 5'd4, 5'd8, 5'd0, 5'd0, 5'd0, 5'd0},
    '{5'd2, 5'd4, 5'd8, 5'd8, 5'd8, 5'd4, 5'd2},
    '{5'd8, 5'd4, 5'd2, 5'd2, 5'd2, 5'd4, 5'd8},
    '{5'd0, 5'd21, 5'd14, 5'd31, 5'd14, 5'd21, 5'd0},
    '{5'd0, 5'd4, 5'd4, 5'd31, 5'd4, 5'd4, 5'd0},
    '{5'd0, 5'd0, 5'd0, 5'd0, 5'd6, 5'd6, 5'd4},
    '{5'd0, 5'd0, 5'd0, 5'd31, 5'd0, 5'd0, 5'd0},
    '{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd6, 5'd6},
    '{5'd1, 5'd2, 5'd2, 5'd4, 5'd8, 5'd8, 5'd16},
    '{5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14},
    '{5'd4, 5'd12, 5'd4, 5'd4, 5'd4, 5'd4, 5'd14},
    '{5'd14, 5'd17, 5'd1, 5'd2, 5'd4, 5'd8, 5'd31},
    '{5'd30, 5'd1, 5'd1, 5'd14, 5'd1, 5'd1, 5'd30},
    '{5'd2, 5'd6, 5'd10, 5'd18, 5'd31, 5'd2, 5'd2},
    '{5'd31, 5'd16, 5'd16, 5'd30, 5'd1, 5'd1, 5'd30},
    '{5'd14, 5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14},
    '{5'd31, 5'd1, 5'd2, 5'd4, 5'd8, 5'd8, 5'd8},
    '{5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14},
    '{5'd14, 5'd17, 5'd17, 5'd15, 5'd1, 5'd1, 5'd14},
    '{5'd0, 5'd6, 5'd6, 5'd0, 5'd6, 5'd6, 5'd0},
    '{5'd0, 5'd6, 5'd6, 5'd0, 5'd6, 5'd6, 5'd4},
    '{5'd2, 5'd4, 5'd8, 5'd16, 5'd8, 5'd4, 5'd2},
    '{5'd0, 5'd31, 5'd0, 5'd31, 5'd0, 5'd0, 5'd0},
    '{5'd8, 5'd4, 5'd2, 5'd1, 5'd2, 5'd4, 5'd8},
    '{5'd14, 5'd17, 5'd1, 5'd2, 5'd4, 5'd0, 5'd4},
    '{5'd14, 5'd17, 5'd23, 5'd21, 5'd23, 5'd16, 5'd14},
    '{5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17},
    '{5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30},
    '{5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14},
    '{5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30},
    '{5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31},
    '{5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16},
    '{5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd15},
    '{5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17},
    '{5'd14, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd14},
    '{5'd7, 5'd2, 5'd2, 5'd2, 5'd18, 5'd18, 5'd12},
    '{5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17},
    '{5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31},
    '{5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17},
    '{5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17},
    '{5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14},
    '{5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16},
    '{5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13},
    '{5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17},
    '{5'd15, 5'd16, 5'd16, 5'd14, 5'd1, 5'd1, 5'd30},
    '{5'd31, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4},
    '{5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14},
    '{5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4},
    '{5'd17, 5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd10},
    '{5'd17, 5'd17, 5'd10, 5'd4, 5'd10, 5'd17, 5'd17},
    '{5'd17, 5'd17, 5'd10, 5'd4, 5'd4, 5'd4, 5'd4},
    '{5'd31, 5'd1, 5'd2, 5'd4, 5'd8, 5'd16, 5'd31},
    '{5'd14, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd14},
    '{5'd16, 5'd8, 5'd8, 5'd4, 5'd2, 5'd2, 5'd1},
    '{5'd14, 5'd2, 5'd2, 5'd2, 5'd2, 5'd2, 5'd14},
    '{5'd4, 5'd10, 5'd17, 5'd0, 5'd0, 5'd0, 5'd0},
    '{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd31},
    '{5'd8, 5'd4, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0},
    '{5'd0, 5'd0, 5'd14, 5'd1, 5'd15, 5'd17, 5'd15},
    '{5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd17, 5'd30},
    '{5'd0, 5'd0, 5'd14, 5'd16, 5'd16, 5'd17, 5'd14},
    '{5'd1, 5'd1, 5'd15, 5'd17, 5'd17, 5'd17, 5'd15},
    '{5'd0, 5'd0, 5'd14, 5'd17, 5'd31, 5'd16, 5'd14},
    '{5'd6, 5'd9, 5'd8, 5'd28, 5'd8, 5'd8, 5'd8},
    '{5'd0, 5'd0, 5'd15, 5'd17, 5'd15, 5'd1, 5'd14},
    '{5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd17, 5'd17},
    '{5'd4, 5'd0, 5'd12, 5'd4, 5'd4, 5'd4, 5'd14},
    '{5'd2, 5'd0, 5'd6, 5'd2, 5'd2, 5'd18, 5'd12},
    '{5'd16, 5'd16, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18},
    '{5'd12, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd14},
    '{5'd0, 5'd0, 5'd26, 5'd21, 5'd21, 5'd17, 5'd17},
    '{5'd0, 5'd0, 5'd30, 5'd17, 5'd17, 5'd17, 5'd17},
    '{5'd0, 5'd0, 5'd14, 5'd17, 5'd17, 5'd17, 5'd14},
    '{5'd0, 5'd0, 5'd30, 5'd17, 5'd30, 5'd16, 5'd16},
    '{5'd0, 5'd0, 5'd15, 5'd17, 5'd15, 5'd1, 5'd1},
    '{5'd0, 5'd0, 5'd22, 5'd25, 5'd16, 5'd16, 5'd16},
    '{5'd0, 5'd0, 5'd15, 5'd16, 5'd14, 5'd1, 5'd30},
    '{5'd8, 5'd8, 5'd28, 5'd8, 5'd8, 5'd9, 5'd6},
    '{5'd0, 5'd0, 5'd17, 5'd17, 5'd17, 5'd19, 5'd13},
    '{5'd0, 5'd0, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4},
    '{5'd0, 5'd0, 5'd17, 5'd17, 5'd21, 5'd21, 5'd10},
    '{5'd0, 5'd0, 5'd17, 5'd10, 5'd4, 5'd10, 5'd17},
    '{5'd0, 5'd0, 5'd17, 5'd17, 5'd15, 5'd1, 5'd14},
    '{5'd0, 5'd0, 5'd31, 5'd2, 5'd4, 5'd8, 5'd31},
    '{5'd6, 5'd4, 5'd4, 5'd24, 5'd4, 5'd4, 5'd6},
    '{5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4},
    '{5'd12, 5'd4, 5'd4, 5'd3, 5'd4, 5'd4, 5'd12},
    '{5'd0, 5'd0, 5'd9, 5'd22, 5'd0, 5'd0, 5'd0}
  };

  // Map a byte to its font slot; anything unprintable shows the question mark
  function automatic logic [6:0] glyph_index(input logic [7:0] code);
    logic [7:0] idx;
    begin
      if (code >= 8'(FONT_FIRST) && code < 8'(FONT_FIRST + FONT_COUNT)) begin
        idx = code - 8'(FONT_FIRST);
      end else begin
        idx = 8'(FONT_QMARK - FONT_FIRST);
      end
      glyph_index = idx[6:0];
    end
  endfunction

  function automatic glyph_row_t font_row(input logic [6:0] idx, input logic [2:0] row);
    glyph_row_t r;
    begin
      r = '0;
      if (idx < 7'(FONT_COUNT) && row < 3'(GLYPH_HEIGHT)) begin
        r = FONT[idx][row];
      end
      font_row = r;
    end
  endfunction

endpackage

FILE: src/clipped_rect_and_glyph_blitter_unit.sv
// Drawing engine for a SCREEN_WIDTH x SCREEN_HEIGHT frame of 16-bit colours.
// Each input word is one command (s_tuser): fill a rectangle, stroke an
// outline as four bands, fill a corner-cut rectangle as two boxes, blit one
// 5x7 character with each set glyph pixel scaled to a glyph_scale square, or
// read back one pixel. Only the read returns a word on the master side:
// read_color in m_tdata and the on-screen flag in m_tuser (colour 0 when off
// screen). Commands run one at a time; s_tready is high only while idle, and
// every command returns to idle before the next is taken. Every box is
// clipped and issued in the box state, then the walker writes one pixel
// per cycle into the single-port-write frame memory. A fill is one box, a
// stroke always four, a corner-cut rectangle two, or none when the cut is
// too large. After the last box is issued the block waits in the drain state
// until the walker is done, then returns to idle. A character visits all 35
// glyph cells in turn, and a set cell adds its clipped scale x scale pixel
// writes; at scale zero it writes nothing. A read issues the memory read in
// the read state and loads the output register in the response state, where
// it waits while the sink still holds an earlier word. The frame store is
// not cleared after reset; reading a pixel never drawn gives an arbitrary
// colour.
module clipped_rect_and_glyph_blitter_unit #(
  parameter int SCREEN_WIDTH  = 256,
  parameter int SCREEN_HEIGHT = 240
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // pos_x[10:0], pos_y[21:11], rect_width[31:22], rect_height[41:32],
  // edge_amount[49:42], glyph_scale[54:50], char_code[62:55],
  // pixel_color[78:63], zero pad[79]
  input  logic [79:0] s_tdata,
  // func[2:0]
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // read_color[15:0]
  output logic [15:0] m_tdata,
  // in_range[0]
  output logic        m_tuser
);

  localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(SCREEN_WIDTH);
  localparam int YW    = $clog2(SCREEN_HEIGHT);

  cgb_pkg::state_t state, state_next;

  // Latched command
  logic [2:0]      func;
  cgb_pkg::coord_t pos_x, pos_y, rect_w, rect_h, edge_amt, scale;
  logic [6:0]      gidx;
  logic [15:0]     color;

  // Box sequencing
  logic [1:0]      step;
  logic [2:0]      grow, gcol;
  cgb_pkg::coord_t xo, yo;

  cgb_pkg::box_t       box;
  logic                go, last_box, start;
  cgb_pkg::walk_stat_t wstat;
  logic [AW-1:0]       wr_addr;
  cgb_pkg::glyph_row_t grow_bits;
  logic                cut_skip, in_rng, rd_en, load_out;
  logic [AW-1:0]       rd_addr;
  logic [15:0]         rd_data;
  cgb_pkg::coord_t     two_e;

  always_comb begin
    two_e     = edge_amt + edge_amt;
    cut_skip  = (rect_w <= two_e) || (rect_h <= two_e);
    grow_bits = cgb_pkg::font_row(gidx, grow);
    box       = '{x: pos_x, y: pos_y, w: rect_w, h: rect_h};
    go        = 1'b0;
    last_box  = 1'b1;
    unique if (func == cgb_pkg::FN_FILL) begin
      go = 1'b1;
    end else if (func == cgb_pkg::FN_STROKE) begin
      go       = 1'b1;
      last_box = (step == 2'd3);
      unique case (step)
        2'd0: box = '{x: pos_x, y: pos_y, w: rect_w, h: edge_amt};
        2'd1: box = '{x: pos_x, y: pos_y + rect_h - edge_amt, w: rect_w, h: edge_amt};
        2'd2: box = '{x: pos_x, y: pos_y, w: edge_amt, h: rect_h};
        default: box = '{x: pos_x + rect_w - edge_amt, y: pos_y, w: edge_amt, h: rect_h};
      endcase
    end else if (func == cgb_pkg::FN_CUT) begin
      go       = !cut_skip;
      last_box = cut_skip || (step == 2'd1);
      if (step == 2'd0) begin
        box = '{x: pos_x + edge_amt, y: pos_y, w: rect_w - two_e, h: rect_h};
      end else begin
        box = '{x: pos_x, y: pos_y + edge_amt, w: rect_w, h: rect_h - two_e};
      end
    end else if (func == cgb_pkg::FN_CHAR) begin
      go       = grow_bits[3'(cgb_pkg::GLYPH_WIDTH - 1) - gcol] && (scale != '0);
      last_box = (grow == 3'(cgb_pkg::GLYPH_HEIGHT - 1)) &&
                 (gcol == 3'(cgb_pkg::GLYPH_WIDTH - 1));
      box      = '{x: pos_x + xo, y: pos_y + yo, w: scale, h: scale};
    end else begin
      go = 1'b0;
    end
  end

  assign in_rng  = (pos_x >= 0) && (pos_x < cgb_pkg::coord_t'(SCREEN_WIDTH)) &&
                   (pos_y >= 0) && (pos_y < cgb_pkg::coord_t'(SCREEN_HEIGHT));
  assign rd_addr = AW'(int'(pos_y[YW-1:0]) * SCREEN_WIDTH + int'(pos_x[XW-1:0]));

  // Control state machine
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    start      = 1'b0;
    rd_en      = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      cgb_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (s_tuser == cgb_pkg::FN_READ) begin
            state_next = cgb_pkg::ST_READ;
          end else if (s_tuser == cgb_pkg::FN_FILL || s_tuser == cgb_pkg::FN_STROKE ||
                       s_tuser == cgb_pkg::FN_CUT || s_tuser == cgb_pkg::FN_CHAR) begin
            state_next = cgb_pkg::ST_BOX;
          end
        end
      end
      cgb_pkg::ST_BOX: begin
        if (!wstat.busy) begin
          start = go;
          if (last_box) begin
            state_next = cgb_pkg::ST_DRAIN;
          end
        end
      end
      cgb_pkg::ST_DRAIN: begin
        if (!wstat.busy) begin
          state_next = cgb_pkg::ST_IDLE;
        end
      end
      cgb_pkg::ST_READ: begin
        rd_en      = 1'b1;
        state_next = cgb_pkg::ST_RESP;
      end
      cgb_pkg::ST_RESP: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = cgb_pkg::ST_IDLE;
        end
      end
      default: state_next = cgb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cgb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Latch the command word; sign-extend coordinates to the working width
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      func     <= s_tuser;
      pos_x    <= cgb_pkg::coord_t'(signed'(s_tdata[10:0]));
      pos_y    <= cgb_pkg::coord_t'(signed'(s_tdata[21:11]));
      rect_w   <= cgb_pkg::coord_t'(s_tdata[31:22]);
      rect_h   <= cgb_pkg::coord_t'(s_tdata[41:32]);
      edge_amt <= cgb_pkg::coord_t'(s_tdata[49:42]);
      scale    <= cgb_pkg::coord_t'(s_tdata[54:50]);
      gidx     <= cgb_pkg::glyph_index(s_tdata[62:55]);
      color    <= s_tdata[78:63];
    end
  end

  // Advance through boxes or glyph cells
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
      grow <= '0;
      gcol <= '0;
      xo   <= '0;
      yo   <= '0;
    end else if (s_tvalid && s_tready) begin
      step <= '0;
      grow <= '0;
      gcol <= '0;
      xo   <= '0;
      yo   <= '0;
    end else if (state == cgb_pkg::ST_BOX && !wstat.busy) begin
      step <= step + 2'd1;
      if (gcol == 3'(cgb_pkg::GLYPH_WIDTH - 1)) begin
        gcol <= '0;
        xo   <= '0;
        grow <= grow + 3'd1;
        yo   <= yo + scale;
      end else begin
        gcol <= gcol + 3'd1;
        xo   <= xo + scale;
      end
    end
  end

  // Output register: hold the word until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= in_rng ? rd_data : 16'd0;
      m_tuser <= in_rng;
    end
  end

  cgb_box_walker #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT),
    .AW           (AW)
  ) u_walker (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .box    (box),
    .stat   (wstat),
    .wr_addr(wr_addr)
  );

  cgb_frame_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk    (clk),
    .wr_en  (wstat.wr_en),
    .wr_addr(wr_addr),
    .wr_data(color),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    wstat.wr_en |-> (int'(wr_addr) < DEPTH))
    else $error("pixel write outside frame");

  a_no_accept_while_drawing: assert property (@(posedge clk) disable iff (rst)
    wstat.busy |-> !s_tready)
    else $error("command accepted while drawing");

  a_read_write_apart: assert property (@(posedge clk) disable iff (rst)
    !(rd_en && wstat.wr_en))
    else $error("read overlaps a pixel write");

  a_result_from_read: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == cgb_pkg::ST_RESP))
    else $error("result raised without a read");

endmodule

FILE: src/cgb_frame_mem.sv
module cgb_frame_mem #(
  parameter int DEPTH = 61440,
  parameter int AW    = 16
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [15:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [15:0]   rd_data
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/cgb_box_walker.sv
module cgb_box_walker #(
  parameter int SCREEN_WIDTH  = 256,
  parameter int SCREEN_HEIGHT = 240,
  parameter int AW            = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  cgb_pkg::box_t     box,
  output cgb_pkg::walk_stat_t stat,
  output logic [AW-1:0]     wr_addr
);

  localparam int XW = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
  localparam int YW = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;

  cgb_pkg::coord_t x_end, y_end, clip_l, clip_r, clip_t, clip_b, last_c_w, last_r_w;
  logic            empty;

  logic [XW-1:0] left, col, last_c;
  logic [YW-1:0] row, last_r;
  logic          busy;

  // Clip the box to the screen
  always_comb begin
    x_end    = box.x + box.w;
    y_end    = box.y + box.h;
    clip_l   = (box.x < 0) ? '0 : box.x;
    clip_t   = (box.y < 0) ? '0 : box.y;
    clip_r   = (x_end > cgb_pkg::coord_t'(SCREEN_WIDTH)) ?
               cgb_pkg::coord_t'(SCREEN_WIDTH) : x_end;
    clip_b   = (y_end > cgb_pkg::coord_t'(SCREEN_HEIGHT)) ?
               cgb_pkg::coord_t'(SCREEN_HEIGHT) : y_end;
    last_c_w = clip_r - cgb_pkg::coord_t'(1);
    last_r_w = clip_b - cgb_pkg::coord_t'(1);
    empty    = (clip_r <= clip_l) || (clip_b <= clip_t);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= !empty;
    end else if (busy && col == last_c && row == last_r) begin
      busy <= 1'b0;
    end
  end

  // Raster scan, one pixel per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      left   <= clip_l[XW-1:0];
      col    <= clip_l[XW-1:0];
      row    <= clip_t[YW-1:0];
      last_c <= last_c_w[XW-1:0];
      last_r <= last_r_w[YW-1:0];
    end else if (busy) begin
      if (col == last_c) begin
        col <= left;
        row <= row + YW'(1);
      end else begin
        col <= col + XW'(1);
      end
    end
  end

  assign wr_addr    = AW'(int'(row) * SCREEN_WIDTH + int'(col));
  assign stat.busy  = busy;
  assign stat.wr_en = busy;

endmodule
